>>> rtl/utx_pkg.sv
// Shared types and constants for the UART transmitter with transmit FIFO.
package utx_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned FRAME_W        = 10;
  localparam int unsigned PERIOD_W       = 16;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd7500;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_PUSH = 1'b1;

  localparam logic START_BIT = 1'b0;
  localparam logic STOP_BIT  = 1'b1;
  localparam logic LINE_IDLE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic push_accepted;
    logic push_rejected;
    logic busy_res;
  } out_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic line_nxt;
    logic busy_nxt;
  } shift_stat_t;

endpackage

>>> rtl/utx_fifo.sv
// Transmit ring FIFO: storage memory, pointers and head-of-queue prefetch.
module utx_fifo
  import utx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_req,
  input  logic [BYTE_W-1:0] push_data,
  input  logic              pop,
  output fifo_stat_t        stat,
  output logic [BYTE_W-1:0] head_data
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [BYTE_W-1:0] mem [FIFO_DEPTH];

  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_inc;
  logic [PTR_W-1:0]  rd_ptr_inc;
  logic              do_push;
  logic [BYTE_W-1:0] rd_data_r;
  logic              fwd_r;
  logic              fwd_nxt;
  logic [BYTE_W-1:0] fwd_data_r;

  always_comb begin
    wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    stat.full  = (wr_ptr_inc == rd_ptr_r);
    stat.empty = (wr_ptr_r == rd_ptr_r);
    do_push    = push_req && !stat.full;
    wr_ptr_nxt = do_push ? wr_ptr_inc : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_inc : rd_ptr_r;
    fwd_nxt    = do_push && (wr_ptr_r == rd_ptr_nxt);
    head_data  = fwd_r ? fwd_data_r : rd_data_r;
  end

  // The read port always prefetches the entry at the next read pointer.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
    rd_data_r  <= mem[rd_ptr_nxt];
    fwd_data_r <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fwd_r    <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fwd_r    <= fwd_nxt;
    end
  end

endmodule

>>> rtl/utx_shifter.sv
// Bit divider, frame shift register, line driver and bit timer control.
module utx_shifter
  import utx_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  input  logic                tick,
  input  logic                start,
  input  fifo_stat_t          fifo_stat,
  input  logic [BYTE_W-1:0]   head_data,
  output logic                pop,
  output shift_stat_t         stat
);

  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] div_r;
  logic [PERIOD_W-1:0] div_nxt;
  logic [FRAME_W-1:0]  frame_r;
  logic [FRAME_W-1:0]  frame_nxt;
  logic                line_r;
  logic                line_nxt;
  logic                run_r;
  logic                run_nxt;

  always_comb begin
    div_nxt   = div_r;
    frame_nxt = frame_r;
    line_nxt  = line_r;
    run_nxt   = run_r;
    pop       = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
    end else if (tick && run_r) begin
      if (div_r >= period_r) begin
        div_nxt = '0;
        if (frame_r != '0) begin
          line_nxt  = frame_r[0];
          frame_nxt = frame_r >> 1;
        end else if (fifo_stat.empty) begin
          run_nxt = 1'b0;
        end else begin
          pop       = 1'b1;
          frame_nxt = {STOP_BIT, head_data, START_BIT};
        end
      end else begin
        div_nxt = div_r + 1'b1;
      end
    end
    stat.line_nxt = line_nxt;
    stat.busy_nxt = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= BIT_PERIOD_RST;
      div_r    <= '0;
      frame_r  <= '0;
      line_r   <= LINE_IDLE;
      run_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      div_r   <= div_nxt;
      frame_r <= frame_nxt;
      line_r  <= line_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule

>>> rtl/uart_tx_with_fifo_unit.sv
// Top level of the 8-N-1 UART transmitter with a transmit ring FIFO.
//
// Each input transaction is either one base clock tick or a byte push, and
// each gives exactly one result transaction from the output register. The
// block takes one transaction every cycle unless the output stalls: the
// divider, shifter and FIFO pointers update together, and the FIFO memory
// keeps the head byte prefetched on its registered read port, so a frame load
// never waits for the memory. The FIFO holds FIFO_DEPTH - 1 bytes; a push to
// a full FIFO is reported as rejected. No clearing pass is needed after reset.
module uart_tx_with_fifo_unit
  import utx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata
);

  logic        in_accept;
  logic        is_push;
  logic        pop;
  logic [BYTE_W-1:0] head_data;
  fifo_stat_t  fifo_stat;
  shift_stat_t shift_stat;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign is_push   = (in_item.req_type == REQ_PUSH);

  utx_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (in_accept && is_push),
    .push_data(in_item.data_byte),
    .pop      (pop),
    .stat     (fifo_stat),
    .head_data(head_data)
  );

  utx_shifter u_shifter (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .tick     (in_accept && (in_item.req_type == REQ_TICK)),
    .start    (in_accept && is_push && !fifo_stat.full),
    .fifo_stat(fifo_stat),
    .head_data(head_data),
    .pop      (pop),
    .stat     (shift_stat)
  );

  always_comb begin
    out_item_nxt.line_level    = shift_stat.line_nxt;
    out_item_nxt.push_accepted = is_push && !fifo_stat.full;
    out_item_nxt.push_rejected = is_push && fifo_stat.full;
    out_item_nxt.busy_res      = shift_stat.busy_nxt;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
